FILE: hw/rtl/sslqg_pkg.sv
package sslqg_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int GAIN_COUNT_DEF = 20;

    localparam int IDX_H = 0;
    localparam int IDX_K = 3;
    localparam int IDX_F = 5;
    localparam int IDX_G = 14;

    localparam logic [1:0] CFG_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE = 2'd1;
    localparam logic [1:0] CFG_DELAY     = 2'd2;
    localparam logic [1:0] CFG_LIMIT     = 2'd3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [15:0] PERIOD_RST    = 16'd20000;
    localparam logic [30:0] AMPLITUDE_RST = 31'd393216;
    localparam logic [31:0] DELAY_RST     = 32'd10000;
    localparam logic [19:0] LIMIT_RST     = 20'd393216;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sslqg_divider.sv
module sslqg_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [48:0] o_quotient,
    output logic [15:0] o_remainder
);

    logic [48:0] r_quo;
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] n_trial;
    logic [16:0] n_shift;

    always_comb begin
        n_shift = {r_rem[15:0], r_quo[48]};
        n_trial = n_shift - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (!n_trial[16]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[47:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[47:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd48) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[15:0];

endmodule

FILE: hw/rtl/state_space_lqg_controller.sv
// Three-state fixed-point state-space controller for a two-sensor plant.
// Input channel (i_valid/o_ready) carries either a gain load (op 0) or a
// control sample (op 1); each accepted transaction yields exactly one
// result transaction on the output channel (o_valid/i_ready).
// Configuration registers are written through i_cfg_valid/o_cfg_ready with
// an index and data; writes should only be made while the block is idle.
// A gain load presents its result in the cycle after acceptance. An inactive
// sample passes through the check state before its result is registered.
// A sample that runs the control law passes through the check state, two
// 49-step restoring divisions (uptime modulo period, then the triangle
// quotient) on one shared divider, the reference state, then 20
// multiply-accumulate steps on one shared 32x32 multiplier. With a zero
// period the divisions are skipped.
// One transaction is worked on at a time; o_ready is low meanwhile and rises
// in the cycle after the result is taken.
// The result is held in an output register until taken, so a stalled
// receiver simply holds the block busy.
// Reset clears the configuration to defaults, the gain table and the
// controller state to zero, and re-arms the fail-safe.
module state_space_lqg_controller #(
    parameter int FRAC_BITS  = sslqg_pkg::FRAC_BITS_DEF,
    parameter int GAIN_COUNT = sslqg_pkg::GAIN_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [4:0]         i_gain_index,
    input  logic signed [31:0] i_gain_value,
    input  logic [17:0]        i_angle_raw,
    input  logic [17:0]        i_position_raw,
    input  logic [39:0]        i_uptime_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_drive_value,
    output logic               o_stopped,
    output logic               o_active,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_REF, S_MAC, S_OUT
    } t_state;

    localparam int GW = $clog2(GAIN_COUNT);

    t_state r_state;
    logic [15:0] r_period;
    logic [30:0] r_amp;
    logic [31:0] r_delay;
    logic [19:0] r_limit;
    logic signed [31:0] r_gain [GAIN_COUNT];
    logic signed [31:0] r_z [3];
    logic signed [31:0] r_nz [2];
    logic r_run;
    logic signed [31:0] r_ang, r_pos, r_err;
    logic [39:0] r_up;
    logic [15:0] r_t;
    logic [4:0]  r_step;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic r_pvalid;
    logic [4:0] r_pstep;
    logic r_valid;
    logic signed [31:0] r_drive;
    logic r_active;

    logic        n_div_start;
    logic [48:0] n_div_a;
    logic        w_div_done;
    logic [48:0] w_quo;
    logic [15:0] w_rem;

    sslqg_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_div_start),
        .i_dividend(n_div_a), .i_divisor(r_period),
        .o_done(w_div_done), .o_quotient(w_quo), .o_remainder(w_rem)
    );

    function automatic logic signed [31:0] conv(input logic [17:0] raw);
        logic [63:0] s;
        s = (64'(raw) * 64'd20) << FRAC_BITS;
        return 32'(s >> 18) - 32'(64'd10 << FRAC_BITS);
    endfunction

    logic signed [31:0] w_ang, w_pos;
    logic [31:0] w_mag;
    always_comb begin
        w_ang = conv(i_angle_raw);
        w_pos = conv(i_position_raw);
        w_mag = r_ang[31] ? 32'(-r_ang) : 32'(r_ang);
    end

    // Operand selection for each multiply step.
    logic signed [31:0] w_g, w_x;
    logic [1:0] w_row;
    logic [1:0] w_col;
    always_comb begin
        w_row = 2'd0;
        w_col = 2'd0;
        w_g = r_gain[GW'(sslqg_pkg::IDX_H)];
        w_x = r_z[0];
        if (r_step < 5'd5) begin
            w_g = r_gain[GW'(r_step)];
            case (r_step)
                5'd0: w_x = r_z[0];
                5'd1: w_x = r_z[1];
                5'd2: w_x = r_z[2];
                5'd3: w_x = r_ang;
                default: w_x = r_err;
            endcase
        end else begin
            w_row = (r_step < 5'd10) ? 2'd0 : ((r_step < 5'd15) ? 2'd1 : 2'd2);
            w_col = 2'(r_step - 5'd5 - 5'(w_row) * 5'd5);
            if (w_col < 2'd3) begin
                w_g = r_gain[GW'(5'(sslqg_pkg::IDX_F) + 5'(w_row) * 5'd3 + 5'(w_col))];
            end else begin
                w_g = r_gain[GW'(5'(sslqg_pkg::IDX_G) + 5'(w_row) * 5'd2)];
            end
            case (w_col)
                2'd0: w_x = r_z[0];
                2'd1: w_x = r_z[1];
                2'd2: w_x = r_z[2];
                default: w_x = r_ang;
            endcase
        end
    end

    // Fifth column of each state row uses the error with the second G gain.
    logic signed [31:0] w_g2;
    logic        w_is_e;
    logic [4:0]  w_last;
    always_comb begin
        w_last = 5'd9 + 5'(w_row) * 5'd5;
        w_is_e = (r_step >= 5'd5) && (r_step == w_last);
        w_g2 = r_gain[GW'(5'(sslqg_pkg::IDX_G) + 5'(w_row) * 5'd2 + 5'd1)];
    end

    logic [48:0] w_tri_num;
    logic [15:0] w_q4;
    logic signed [49:0] w_ref;
    logic [48:0] w_a4;
    always_comb begin
        w_a4 = {16'd0, r_amp, 2'b00};
        w_tri_num = w_a4 * 49'(r_t);
        w_q4 = r_period >> 2;
        if (r_t < w_q4) begin
            w_ref = $signed({1'b0, w_quo});
        end else if (17'(r_t) > ((18'(r_period) * 18'd3) >> 2)) begin
            w_ref = $signed({1'b0, w_quo}) - $signed({1'b0, w_a4});
        end else begin
            w_ref = $signed({18'd0, r_amp, 1'b0}) - $signed({1'b0, w_quo});
        end
    end

    logic signed [63:0] w_sh;
    always_comb begin
        w_sh = r_prod >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= sslqg_pkg::PERIOD_RST;
            r_amp    <= sslqg_pkg::AMPLITUDE_RST;
            r_delay  <= sslqg_pkg::DELAY_RST;
            r_limit  <= sslqg_pkg::LIMIT_RST;
            r_run    <= 1'b1;
            r_valid  <= 1'b0;
            r_pvalid <= 1'b0;
            for (int i = 0; i < GAIN_COUNT; i++) r_gain[i] <= '0;
            for (int i = 0; i < 3; i++) r_z[i] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sslqg_pkg::CFG_PERIOD:    r_period <= i_cfg_data[15:0];
                    sslqg_pkg::CFG_AMPLITUDE: r_amp <= i_cfg_data[30:0];
                    sslqg_pkg::CFG_DELAY:     r_delay <= i_cfg_data;
                    sslqg_pkg::CFG_LIMIT:     r_limit <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_drive  <= '0;
                        r_active <= 1'b0;
                        if (i_op == sslqg_pkg::OP_LOAD) begin
                            if (i_gain_index < 5'(GAIN_COUNT))
                                r_gain[GW'(i_gain_index)] <= i_gain_value;
                            r_state <= S_OUT;
                            r_valid <= 1'b1;
                        end else begin
                            r_ang <= w_ang;
                            r_pos <= w_pos;
                            r_up  <= i_uptime_ms;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_mag > 32'(r_limit)) begin
                        r_run   <= 1'b0;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else if (r_run && r_up > 40'(r_delay)) begin
                        r_state <= (r_period == 16'd0) ? S_REF : S_DIV1;
                        r_t     <= '0;
                    end else begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_DIV1: r_state <= S_WAIT1;
                S_WAIT1: begin
                    if (w_div_done) begin
                        r_t <= w_rem;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: r_state <= S_WAIT2;
                S_WAIT2: if (w_div_done) r_state <= S_REF;
                S_REF: begin
                    r_err  <= sslqg_pkg::sat32($signed({{32{r_pos[31]}}, r_pos})
                              - ((r_period == 16'd0) ? 64'sd0 : 64'(w_ref)));
                    r_step <= '0;
                    r_acc  <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (!r_pvalid && r_step < 5'd20) begin
                        // issue a product
                        r_prod   <= (w_is_e ? w_g2 : w_g) * (w_is_e ? r_err : w_x);
                        r_pvalid <= 1'b1;
                        r_pstep  <= r_step;
                        r_step   <= r_step + 5'd1;
                    end else begin
                        r_pvalid <= 1'b0;
                    end
                    if (r_pvalid) begin
                        if (r_pstep == 5'd4 || r_pstep == 5'd9 || r_pstep == 5'd14
                            || r_pstep == 5'd19) begin
                            if (r_pstep == 5'd4) begin
                                r_drive <= sslqg_pkg::sat32(-64'(sslqg_pkg::sat32(r_acc
                                           + w_sh)));
                            end else if (r_pstep == 5'd9) begin
                                r_nz[0] <= sslqg_pkg::sat32(r_acc + w_sh);
                            end else if (r_pstep == 5'd14) begin
                                r_nz[1] <= sslqg_pkg::sat32(r_acc + w_sh);
                            end
                            r_acc <= '0;
                        end else begin
                            r_acc <= r_acc + w_sh;
                        end
                        if (r_pstep == 5'd19) begin
                            r_z[0]   <= r_nz[0];
                            r_z[1]   <= r_nz[1];
                            r_z[2]   <= sslqg_pkg::sat32(r_acc + w_sh);
                            r_active <= 1'b1;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        n_div_start = (r_state == S_DIV1) || (r_state == S_DIV2);
        n_div_a = (r_state == S_DIV1) ? {9'd0, r_up} : w_tri_num;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_valid;
    assign o_drive_value = r_drive;
    assign o_stopped     = !r_run;
    assign o_active      = r_active;

endmodule

FILE: hw/rtl/sslqg_checker.sv
module sslqg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_drive_value,
    input logic        o_stopped,
    input logic        o_active
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive_value))
        else $error("Result changed while stalled.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("Input ready while a result waits.");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_drive_value == 32'd0)
        else $error("Inactive result carries a drive.");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stopped |=> o_stopped)
        else $error("Stop flag cleared without reset.");

    a_stop_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_active |-> !o_stopped)
        else $error("Active result while stopped.");

endmodule

bind state_space_lqg_controller sslqg_checker u_sslqg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_drive_value(o_drive_value),
    .o_stopped(o_stopped), .o_active(o_active)
);
